@@ hdl/triangle_circumcircle_core_macros.svh @@
// Assertion macros for the triangle circumcircle core.
// Used by triangle_circumcircle_core.sv; no other dependencies.
`ifndef TRIANGLE_CIRCUMCIRCLE_CORE_MACROS_SVH
`define TRIANGLE_CIRCUMCIRCLE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define TCC_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TCC_ASSERT(lbl, prop, msg) \
  `TCC_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`else
`define TCC_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define TCC_ASSERT(lbl, prop, msg)
`endif
`endif

@@ hdl/tcc_pkg.sv @@
// Shared constants for the triangle circumcircle core.
// No dependencies.
`default_nettype none
package tcc_pkg;
  localparam int unsigned COORD_BITS_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF  = 8;
  localparam int unsigned OUT_W          = 32;
endpackage
`default_nettype wire

@@ hdl/tcc_if.sv @@
// Request and result channels of the triangle circumcircle core.
// Depends on tcc_pkg.
`default_nettype none
interface tcc_tri_if #(
  parameter int unsigned CW = tcc_pkg::COORD_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] x1;
  logic signed [CW-1:0] y1;
  logic signed [CW-1:0] x2;
  logic signed [CW-1:0] y2;
  logic signed [CW-1:0] x3;
  logic signed [CW-1:0] y3;

  modport source (output valid, x1, y1, x2, y2, x3, y3, input ready);
  modport sink   (input valid, x1, y1, x2, y2, x3, y3, output ready);
endinterface

interface tcc_circ_if;
  import tcc_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] center_x;
  logic signed [OUT_W-1:0] center_y;
  logic [OUT_W-1:0]        radius;
  logic                    degenerate;
  logic                    saturated;

  modport source (output valid, center_x, center_y, radius, degenerate, saturated,
                  input ready);
  modport sink   (input valid, center_x, center_y, radius, degenerate, saturated,
                  output ready);
endinterface
`default_nettype wire

@@ hdl/tcc_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, several lanes sharing a divisor.
// Depends on tcc_pkg for defaults.
`default_nettype none
module tcc_div #(
  parameter int unsigned NQ    = 3 * tcc_pkg::COORD_BITS_DEF + tcc_pkg::FRAC_BITS_DEF + 4,
  parameter int unsigned DEN_W = 2 * tcc_pkg::COORD_BITS_DEF + 3,
  parameter int unsigned LANES = 3,
  parameter int unsigned TAG_W = 2 * tcc_pkg::COORD_BITS_DEF + 3
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  logic [LANES-1:0][NQ-1:0]       num_i,
  input  logic [DEN_W-1:0]               den_i,
  input  logic [TAG_W-1:0]               tag_i,
  output logic                           valid_o,
  output logic [LANES-1:0][NQ-1:0]       quo_o,
  output logic [LANES-1:0]               rem_nz_o,
  output logic [TAG_W-1:0]               tag_o
);
  logic [LANES-1:0][NQ-1:0]    nq_q  [NQ];
  logic [LANES-1:0][DEN_W-1:0] rem_q [NQ];
  logic [DEN_W-1:0]            den_q [NQ];
  logic [TAG_W-1:0]            tag_q [NQ];
  logic [NQ-1:0]               v_q;

  for (genvar k = 0; k < NQ; k++) begin : g_stage
    logic [LANES-1:0][NQ-1:0]    nq_in;
    logic [LANES-1:0][DEN_W-1:0] rem_in;
    logic [DEN_W-1:0]            den_in;
    logic [TAG_W-1:0]            tag_in;
    logic [LANES-1:0][NQ-1:0]    nq_d;
    logic [LANES-1:0][DEN_W-1:0] rem_d;

    if (k == 0) begin : g_first
      assign nq_in  = num_i;
      assign rem_in = '0;
      assign den_in = den_i;
      assign tag_in = tag_i;
    end else begin : g_next
      assign nq_in  = nq_q[k-1];
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign tag_in = tag_q[k-1];
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [DEN_W:0] cur;
      logic           ge;
      assign cur      = {rem_in[l], nq_in[l][NQ-1]};
      assign ge       = cur >= {1'b0, den_in};
      assign rem_d[l] = DEN_W'(ge ? cur - {1'b0, den_in} : cur);
      assign nq_d[l]  = {nq_in[l][NQ-2:0], ge};
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nq_q[k]  <= nq_d;
        rem_q[k] <= rem_d;
        den_q[k] <= den_in;
        tag_q[k] <= tag_in;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NQ-2:0], valid_i};
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_out
    assign rem_nz_o[l] = |rem_q[NQ-1][l];
  end

  assign quo_o   = nq_q[NQ-1];
  assign tag_o   = tag_q[NQ-1];
  assign valid_o = v_q[NQ-1];
endmodule
`default_nettype wire

@@ hdl/triangle_circumcircle_core.sv @@
// Circumcircle of a triangle: centre rounded to nearest and radius floored, both in fixed
// point with FRAC_BITS fraction bits and saturated to 32 bits; collinear vertices give
// degenerate with zero fields. One triangle is taken every cycle while the result is not
// stalled; the square-root and divider pipelines resolve one result bit per stage. A
// stalled result freezes the whole pipeline; nothing is dropped.
// Depends on tcc_pkg, tcc_if, tcc_div and triangle_circumcircle_core_macros.svh.
`default_nettype none
`include "triangle_circumcircle_core_macros.svh"
module triangle_circumcircle_core #(
  parameter int unsigned COORD_BITS = tcc_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = tcc_pkg::FRAC_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tcc_tri_if.sink    req_i,
  tcc_circ_if.source rsp_o
);
  import tcc_pkg::*;

  localparam int unsigned C    = COORD_BITS;
  localparam int unsigned F    = FRAC_BITS;
  localparam int unsigned DXW  = C + 1;
  localparam int unsigned PW   = 2 * C + 2;
  localparam int unsigned AW   = 2 * C + 3;
  localparam int unsigned SW   = 2 * C + 1;
  localparam int unsigned MW   = 3 * C + 3;
  localparam int unsigned NW   = 3 * C + 4;
  localparam int unsigned NMW  = 3 * C + 3;
  localparam int unsigned AMW  = 2 * C + 2;
  localparam int unsigned DW   = AMW + 1;
  localparam int unsigned TMW  = NMW + F + 1;
  localparam int unsigned TW   = TMW + 1;
  localparam int unsigned RB   = TMW;
  localparam int unsigned HL   = (NMW + 1) / 2;
  localparam int unsigned HH   = NMW - HL;
  localparam int unsigned NSQ  = 2 * NMW;
  localparam int unsigned NF   = 9;
  localparam int unsigned TGW  = 3 + 2 * C;
  localparam int unsigned TOW  = RB + 2;
  localparam int unsigned EW   = (TOW > OUT_W + 1) ? TOW : OUT_W + 1;
  localparam logic signed [EW-1:0] CMAX = EW'(2147483647);
  localparam logic signed [EW-1:0] CMIN = ~CMAX;

  typedef struct packed {
    logic [TMW-1:0] tmx;
    logic [TMW-1:0] tmy;
    logic           negx;
    logic           negy;
    logic           degen;
    logic [DW-1:0]  den;
    logic [C-1:0]   bx;
    logic [C-1:0]   by;
  } sq_pay_t;

  logic en;
  assign en        = !rsp_o.valid || rsp_o.ready;
  assign req_i.ready = en;

  logic [NF-1:0] vld_q;

  // front stages
  logic [C-1:0]           a_bx_q, a_by_q, b_bx_q, b_by_q, c_bx_q, c_by_q;
  logic [C-1:0]           d_bx_q, d_by_q, e_bx_q, e_by_q, f_bx_q, f_by_q;
  logic signed [DXW-1:0]  a_dx2_q, a_dy2_q, a_dx3_q, a_dy3_q;
  logic signed [DXW-1:0]  b_dx2_q, b_dy2_q, b_dx3_q, b_dy3_q;
  logic signed [DXW-1:0]  c_dx2_q, c_dy2_q, c_dx3_q, c_dy3_q;
  logic signed [PW-1:0]   b_p1_q, b_p2_q, b_sq1_q, b_sq2_q, b_sq3_q, b_sq4_q;
  logic signed [AW-1:0]   c_a_q;
  logic [SW-1:0]          c_s2_q, c_s3_q;
  logic signed [MW-1:0]   d_m1_q, d_m2_q, d_m3_q, d_m4_q;
  logic                   d_degen_q, d_aneg_q, e_degen_q, f_degen_q;
  logic [AMW-1:0]         d_am_q, e_am_q, f_am_q;
  logic signed [NW-1:0]   e_nx_q, e_ny_q;
  logic signed [TW-1:0]   f_tx_q, f_ty_q;
  logic [NMW-1:0]         f_nmx_q, f_nmy_q;
  logic [2*HH-1:0]        g_hhx_q, g_hhy_q;
  logic [HH+HL-1:0]       g_hlx_q, g_hly_q;
  logic [2*HL-1:0]        g_llx_q, g_lly_q;
  sq_pay_t                g_pay_q, h_pay_q, i_pay_q;
  logic [NSQ-1:0]         h_nsx_q, h_nsy_q;
  logic [NSQ:0]           i_sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NF-2:0], req_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_bx_q  <= req_i.x1;
      a_by_q  <= req_i.y1;
      a_dx2_q <= DXW'(req_i.x2) - DXW'(req_i.x1);
      a_dy2_q <= DXW'(req_i.y2) - DXW'(req_i.y1);
      a_dx3_q <= DXW'(req_i.x3) - DXW'(req_i.x1);
      a_dy3_q <= DXW'(req_i.y3) - DXW'(req_i.y1);

      b_bx_q  <= a_bx_q;
      b_by_q  <= a_by_q;
      b_dx2_q <= a_dx2_q;
      b_dy2_q <= a_dy2_q;
      b_dx3_q <= a_dx3_q;
      b_dy3_q <= a_dy3_q;
      b_p1_q  <= a_dx2_q * a_dy3_q;
      b_p2_q  <= a_dx3_q * a_dy2_q;
      b_sq1_q <= a_dx2_q * a_dx2_q;
      b_sq2_q <= a_dy2_q * a_dy2_q;
      b_sq3_q <= a_dx3_q * a_dx3_q;
      b_sq4_q <= a_dy3_q * a_dy3_q;

      c_bx_q  <= b_bx_q;
      c_by_q  <= b_by_q;
      c_dx2_q <= b_dx2_q;
      c_dy2_q <= b_dy2_q;
      c_dx3_q <= b_dx3_q;
      c_dy3_q <= b_dy3_q;
      c_a_q   <= AW'(b_p1_q) - AW'(b_p2_q);
      c_s2_q  <= SW'(b_sq1_q + b_sq2_q);
      c_s3_q  <= SW'(b_sq3_q + b_sq4_q);

      d_bx_q    <= c_bx_q;
      d_by_q    <= c_by_q;
      d_m1_q    <= c_dy3_q * $signed({1'b0, c_s2_q});
      d_m2_q    <= c_dy2_q * $signed({1'b0, c_s3_q});
      d_m3_q    <= c_dx2_q * $signed({1'b0, c_s3_q});
      d_m4_q    <= c_dx3_q * $signed({1'b0, c_s2_q});
      d_degen_q <= (c_a_q == '0);
      d_aneg_q  <= c_a_q[AW-1];
      d_am_q    <= AMW'(c_a_q[AW-1] ? -c_a_q : c_a_q);

      // sign of a folded into the numerators here
      e_bx_q    <= d_bx_q;
      e_by_q    <= d_by_q;
      e_degen_q <= d_degen_q;
      e_am_q    <= d_am_q;
      e_nx_q    <= NW'(d_aneg_q ? d_m2_q : d_m1_q) - NW'(d_aneg_q ? d_m1_q : d_m2_q);
      e_ny_q    <= NW'(d_aneg_q ? d_m4_q : d_m3_q) - NW'(d_aneg_q ? d_m3_q : d_m4_q);

      f_bx_q    <= e_bx_q;
      f_by_q    <= e_by_q;
      f_degen_q <= e_degen_q;
      f_am_q    <= e_am_q;
      f_tx_q    <= (TW'(e_nx_q) <<< F) + TW'($signed({1'b0, e_am_q}));
      f_ty_q    <= (TW'(e_ny_q) <<< F) + TW'($signed({1'b0, e_am_q}));
      f_nmx_q   <= NMW'(e_nx_q[NW-1] ? -e_nx_q : e_nx_q);
      f_nmy_q   <= NMW'(e_ny_q[NW-1] ? -e_ny_q : e_ny_q);

      g_pay_q.negx  <= f_tx_q[TW-1];
      g_pay_q.negy  <= f_ty_q[TW-1];
      g_pay_q.tmx   <= TMW'(f_tx_q[TW-1] ? -f_tx_q : f_tx_q);
      g_pay_q.tmy   <= TMW'(f_ty_q[TW-1] ? -f_ty_q : f_ty_q);
      g_pay_q.degen <= f_degen_q;
      g_pay_q.den   <= {f_am_q, 1'b0};
      g_pay_q.bx    <= f_bx_q;
      g_pay_q.by    <= f_by_q;
      g_hhx_q <= f_nmx_q[NMW-1:HL] * f_nmx_q[NMW-1:HL];
      g_hlx_q <= f_nmx_q[NMW-1:HL] * f_nmx_q[HL-1:0];
      g_llx_q <= f_nmx_q[HL-1:0] * f_nmx_q[HL-1:0];
      g_hhy_q <= f_nmy_q[NMW-1:HL] * f_nmy_q[NMW-1:HL];
      g_hly_q <= f_nmy_q[NMW-1:HL] * f_nmy_q[HL-1:0];
      g_lly_q <= f_nmy_q[HL-1:0] * f_nmy_q[HL-1:0];

      h_pay_q <= g_pay_q;
      h_nsx_q <= (NSQ'(g_hhx_q) << (2 * HL)) + (NSQ'(g_hlx_q) << (HL + 1)) + NSQ'(g_llx_q);
      h_nsy_q <= (NSQ'(g_hhy_q) << (2 * HL)) + (NSQ'(g_hly_q) << (HL + 1)) + NSQ'(g_lly_q);

      i_pay_q <= h_pay_q;
      i_sum_q <= (NSQ + 1)'(h_nsx_q) + (NSQ + 1)'(h_nsy_q);
    end
  end

  // integer square root of (Nx^2 + Ny^2) * 2^(2F), one root bit per stage
  logic [2*RB-1:0] sq_arg_q  [RB];
  logic [RB-1:0]   sq_root_q [RB];
  logic [RB:0]     sq_rem_q  [RB];
  sq_pay_t         sq_pay_q  [RB];
  logic [RB-1:0]   sq_v_q;

  for (genvar k = 0; k < RB; k++) begin : g_sq
    logic [2*RB-1:0] arg_in;
    logic [RB-1:0]   root_in;
    logic [RB:0]     rem_in;
    sq_pay_t         pay_in;
    logic [RB+2:0]   cur;
    logic [RB+2:0]   trial;
    logic            ge;

    if (k == 0) begin : g_first
      assign arg_in  = (2 * RB)'(i_sum_q) << (2 * F);
      assign root_in = '0;
      assign rem_in  = '0;
      assign pay_in  = i_pay_q;
    end else begin : g_next
      assign arg_in  = sq_arg_q[k-1];
      assign root_in = sq_root_q[k-1];
      assign rem_in  = sq_rem_q[k-1];
      assign pay_in  = sq_pay_q[k-1];
    end

    assign cur   = {rem_in, arg_in[2*RB-1 -: 2]};
    assign trial = {1'b0, root_in, 2'b01};
    assign ge    = cur >= trial;

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_arg_q[k]  <= arg_in << 2;
        sq_root_q[k] <= {root_in[RB-2:0], ge};
        sq_rem_q[k]  <= (RB + 1)'(ge ? cur - trial : cur);
        sq_pay_q[k]  <= pay_in;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_v_q <= '0;
    end else if (en) begin
      sq_v_q <= {sq_v_q[RB-2:0], vld_q[NF-1]};
    end
  end

  // centre numerators and root divided by 2|a|
  logic [2:0][RB-1:0] dv_num, dv_quo;
  logic [2:0]         dv_nz;
  logic [TGW-1:0]     dv_tag_in, dv_tag;
  logic               dv_valid;

  assign dv_num    = {sq_root_q[RB-1], sq_pay_q[RB-1].tmy, sq_pay_q[RB-1].tmx};
  assign dv_tag_in = {sq_pay_q[RB-1].negx, sq_pay_q[RB-1].negy, sq_pay_q[RB-1].degen,
                      sq_pay_q[RB-1].bx, sq_pay_q[RB-1].by};

  tcc_div #(
    .NQ    (RB),
    .DEN_W (DW),
    .LANES (3),
    .TAG_W (TGW)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (sq_v_q[RB-1]),
    .num_i    (dv_num),
    .den_i    (sq_pay_q[RB-1].den),
    .tag_i    (dv_tag_in),
    .valid_o  (dv_valid),
    .quo_o    (dv_quo),
    .rem_nz_o (dv_nz),
    .tag_o    (dv_tag)
  );

  // floor of the signed centre quotients, radius clip
  logic               dv_negx, dv_negy, dv_degen;
  logic [C-1:0]       dv_bx, dv_by;
  logic [RB:0]        qax, qay;
  logic               rad_big;
  logic [OUT_W-1:0]   rad_val;

  assign {dv_negx, dv_negy, dv_degen, dv_bx, dv_by} = dv_tag;
  assign qax = {1'b0, dv_quo[0]} + (RB + 1)'(dv_nz[0]);
  assign qay = {1'b0, dv_quo[1]} + (RB + 1)'(dv_nz[1]);

  if (RB > OUT_W) begin : g_rad_wide
    assign rad_big = |dv_quo[2][RB-1:OUT_W];
    assign rad_val = dv_quo[2][OUT_W-1:0];
  end else begin : g_rad_narrow
    assign rad_big = 1'b0;
    assign rad_val = OUT_W'(dv_quo[2]);
  end

  logic                p_v_q;
  logic signed [RB:0]  p_qx_q, p_qy_q;
  logic [OUT_W-1:0]    p_rad_q;
  logic                p_radsat_q, p_degen_q;
  logic [C-1:0]        p_bx_q, p_by_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_qx_q     <= dv_negx ? -$signed(qax) : $signed({1'b0, dv_quo[0]});
      p_qy_q     <= dv_negy ? -$signed(qay) : $signed({1'b0, dv_quo[1]});
      p_rad_q    <= rad_big ? '1 : rad_val;
      p_radsat_q <= rad_big;
      p_degen_q  <= dv_degen;
      p_bx_q     <= dv_bx;
      p_by_q     <= dv_by;
    end
  end

  // vertex 1 added back, then 32-bit clip
  logic signed [EW-1:0] totx, toty;
  logic                 satx, saty;
  logic [OUT_W-1:0]     cx, cy;

  assign totx = EW'((TOW'($signed(p_bx_q)) <<< F) + TOW'(p_qx_q));
  assign toty = EW'((TOW'($signed(p_by_q)) <<< F) + TOW'(p_qy_q));

  always_comb begin
    satx = 1'b1;
    saty = 1'b1;
    if (totx > CMAX) begin
      cx = CMAX[OUT_W-1:0];
    end else if (totx < CMIN) begin
      cx = CMIN[OUT_W-1:0];
    end else begin
      cx   = totx[OUT_W-1:0];
      satx = 1'b0;
    end
    if (toty > CMAX) begin
      cy = CMAX[OUT_W-1:0];
    end else if (toty < CMIN) begin
      cy = CMIN[OUT_W-1:0];
    end else begin
      cy   = toty[OUT_W-1:0];
      saty = 1'b0;
    end
  end

  logic             o_v_q;
  logic [OUT_W-1:0] o_cx_q, o_cy_q, o_rad_q;
  logic             o_degen_q, o_sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else if (en) begin
      p_v_q <= dv_valid;
      o_v_q <= p_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      o_degen_q <= p_degen_q;
      o_cx_q    <= p_degen_q ? '0 : cx;
      o_cy_q    <= p_degen_q ? '0 : cy;
      o_rad_q   <= p_degen_q ? '0 : p_rad_q;
      o_sat_q   <= !p_degen_q && (satx || saty || p_radsat_q);
    end
  end

  assign rsp_o.valid      = o_v_q;
  assign rsp_o.center_x   = $signed(o_cx_q);
  assign rsp_o.center_y   = $signed(o_cy_q);
  assign rsp_o.radius     = o_rad_q;
  assign rsp_o.degenerate = o_degen_q;
  assign rsp_o.saturated  = o_sat_q;

  `TCC_ASSERT(a_degen_zero, rsp_o.valid && rsp_o.degenerate |-> rsp_o.center_x == '0 && rsp_o.center_y == '0 && rsp_o.radius == '0 && !rsp_o.saturated, "degenerate result with nonzero fields")
  `TCC_ASSERT(a_sqrt_frozen, !en |=> $stable(sq_v_q) && $stable(vld_q), "pipeline moved while stalled")
  `TCC_ASSERT(a_req_enters, req_i.valid && req_i.ready |=> vld_q[0], "accepted request not in first stage")
endmodule
`default_nettype wire
